// ===== hdl/ord_pkg.sv =====
package ord_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP        = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic [STATUS_W-1:0]       status;
        logic                      is_empty;
        logic                      tail_at_end;
    } result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                pop_ok;
        logic                is_empty;
        logic                tail_at_end;
    } resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT,
        ST_SHIFT_LAST,
        ST_WRITE_FRONT,
        ST_RESP
    } state_t;

endpackage

// ===== hdl/output_restricted_deque.sv =====
// Output-restricted deque over a linear slot array.
// Request channel: request (op, value) is taken at a rising edge with start
// high and busy low. busy stays high until the result has been shown.
// Result channel: done is high for one cycle with result valid; the result
// is taken at the edge that ends that cycle. The receiver cannot stall.
// Sequence of states from the accepting edge to done:
//   rear push, pop, unused op, refused push, push into an empty queue, or
//   front push that moves the head down: DECODE, then RESP with done.
//   front push into a non-empty queue with the head at slot 0 and room left:
//   DECODE, SHIFT, SHIFT_LAST and WRITE_FRONT, then RESP; the store has one
//   write port and moves one entry up per cycle in SHIFT. busy drops in the cycle after done.
// Reset: queue empty, head and tail at slot 0, sequencer idle. The entry
// array is not cleared; an entry is only read after it has been written.
module output_restricted_deque #(
    parameter int DEPTH      = ord_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ord_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output ord_pkg::result_t  result
);

    localparam int IW = $clog2(DEPTH);

    ord_pkg::mem_ctl_t     mem_ctl;
    ord_pkg::resp_t        resp;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [ord_pkg::VALUE_W-1:0] popped_fit;

    ord_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .resp    (resp)
    );

    ord_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    generate
        if (DATA_WIDTH >= ord_pkg::VALUE_W)
        begin : g_trunc
            assign popped_fit = rd_data[ord_pkg::VALUE_W-1:0];
        end
        else
        begin : g_sext
            assign popped_fit = {{(ord_pkg::VALUE_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}},
                                 rd_data};
        end
    endgenerate

    always_comb
    begin
        result.status      = resp.status;
        result.is_empty    = resp.is_empty;
        result.tail_at_end = resp.tail_at_end;
        if (resp.pop_ok)
        begin
            result.popped_value = popped_fit;
        end
        else if (resp.status == ord_pkg::STATUS_EMPTY)
        begin
            result.popped_value = '1;
        end
        else
        begin
            result.popped_value = '0;
        end
    end

    assign done = resp.valid;

endmodule

// ===== hdl/ord_store.sv =====
module ord_store #(
    parameter int DEPTH      = ord_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEFAULT,
    localparam int IW        = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  ord_pkg::mem_ctl_t     mem_ctl,
    input  logic [IW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [IW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ord_ctrl.sv =====
module ord_ctrl #(
    parameter int DEPTH      = ord_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEFAULT,
    localparam int IW        = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ord_pkg::request_t     request,
    output logic                  busy,
    output ord_pkg::mem_ctl_t     mem_ctl,
    output logic [IW-1:0]         wr_addr,
    output logic [DATA_WIDTH-1:0] wr_data,
    output logic [IW-1:0]         rd_addr,
    input  logic [DATA_WIDTH-1:0] rd_data,
    output ord_pkg::resp_t        resp
);

    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    ord_pkg::state_t state_reg, state_next;

    logic [ord_pkg::OP_W-1:0]     op_reg, op_next;
    logic [DATA_WIDTH-1:0]        value_reg, value_next;
    logic [IW-1:0]                head_reg, head_next;
    logic [IW-1:0]                tail_reg, tail_next;
    logic                         empty_reg, empty_next;
    logic [IW-1:0]                ptr_reg, ptr_next;
    logic                         pend_reg, pend_next;
    logic [ord_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         pop_ok_reg, pop_ok_next;
    logic [DATA_WIDTH-1:0]        value_fit;

    generate
        if (DATA_WIDTH <= ord_pkg::VALUE_W)
        begin : g_narrow
            assign value_fit = request.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign value_fit = {{(DATA_WIDTH - ord_pkg::VALUE_W){1'b0}}, request.value};
        end
    endgenerate

    assign busy = (state_reg != ord_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ord_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ord_pkg::ST_DECODE;
                end
            end
            ord_pkg::ST_DECODE:
            begin
                if (op_reg == ord_pkg::OP_PUSH_FRONT && !empty_reg
                    && head_reg == '0 && tail_reg != LAST)
                begin
                    state_next = ord_pkg::ST_SHIFT;
                end
                else
                begin
                    state_next = ord_pkg::ST_RESP;
                end
            end
            ord_pkg::ST_SHIFT:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = ord_pkg::ST_SHIFT_LAST;
                end
            end
            ord_pkg::ST_SHIFT_LAST:  state_next = ord_pkg::ST_WRITE_FRONT;
            ord_pkg::ST_WRITE_FRONT: state_next = ord_pkg::ST_RESP;
            ord_pkg::ST_RESP:        state_next = ord_pkg::ST_IDLE;
            default:                 state_next = ord_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        mem_ctl     = '0;
        wr_addr     = '0;
        wr_data     = value_reg;
        rd_addr     = head_reg;
        resp        = '0;
        case (state_reg)
            ord_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = request.op;
                    value_next = value_fit;
                end
            end
            ord_pkg::ST_DECODE:
            begin
                status_next = ord_pkg::STATUS_DONE;
                pop_ok_next = 1'b0;
                pend_next   = 1'b0;
                case (op_reg)
                    ord_pkg::OP_PUSH_FRONT:
                    begin
                        if (empty_reg)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            head_next     = '0;
                            tail_next     = '0;
                            empty_next    = 1'b0;
                        end
                        else if (head_reg == '0 && tail_reg == LAST)
                        begin
                            status_next = ord_pkg::STATUS_FULL;
                        end
                        else if (head_reg == '0)
                        begin
                            ptr_next = tail_reg;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = head_reg - IW'(1);
                            head_next     = head_reg - IW'(1);
                        end
                    end
                    ord_pkg::OP_PUSH_REAR:
                    begin
                        if (empty_reg)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            head_next     = '0;
                            tail_next     = '0;
                            empty_next    = 1'b0;
                        end
                        else if (tail_reg == LAST)
                        begin
                            status_next = ord_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = tail_reg + IW'(1);
                            tail_next     = tail_reg + IW'(1);
                        end
                    end
                    ord_pkg::OP_POP:
                    begin
                        if (empty_reg)
                        begin
                            status_next = ord_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            mem_ctl.rd_en = 1'b1;
                            pop_ok_next   = 1'b1;
                            if (head_reg == tail_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                head_next = head_reg + IW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ord_pkg::STATUS_DONE;
                    end
                endcase
            end
            ord_pkg::ST_SHIFT:
            begin
                // read slot ptr, write the slot read last cycle one place up
                mem_ctl.rd_en = 1'b1;
                rd_addr       = ptr_reg;
                mem_ctl.wr_en = pend_reg;
                wr_addr       = ptr_reg + IW'(2);
                wr_data       = rd_data;
                pend_next     = 1'b1;
                if (ptr_reg != '0)
                begin
                    ptr_next = ptr_reg - IW'(1);
                end
            end
            ord_pkg::ST_SHIFT_LAST:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = ptr_reg + IW'(1);
                wr_data       = rd_data;
            end
            ord_pkg::ST_WRITE_FRONT:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = '0;
                tail_next     = tail_reg + IW'(1);
            end
            ord_pkg::ST_RESP:
            begin
                resp.valid       = 1'b1;
                resp.status      = status_reg;
                resp.pop_ok      = pop_ok_reg;
                resp.is_empty    = empty_reg;
                resp.tail_at_end = !empty_reg && (tail_reg == LAST);
            end
            default:
            begin
                resp = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ord_pkg::ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            empty_reg  <= 1'b1;
            ptr_reg    <= '0;
            pend_reg   <= 1'b0;
            status_reg <= ord_pkg::STATUS_DONE;
            pop_ok_reg <= 1'b0;
            op_reg     <= ord_pkg::OP_PUSH_FRONT;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            ptr_reg    <= ptr_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
            op_reg     <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/ord_checker.sv =====
module ord_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input ord_pkg::request_t request,
    input logic              busy,
    input logic              done,
    input ord_pkg::result_t  result
);

    // a request is held off until its result has gone out
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a request");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("busy held after result");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ord_pkg::STATUS_EMPTY |->
            result.is_empty && result.popped_value == -32'sd1)
        else $error("empty pop reported wrongly");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.tail_at_end |-> !result.is_empty)
        else $error("last slot flagged on empty queue");

endmodule

bind output_restricted_deque ord_checker u_ord_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
